// File: rtl/uvn_cam_pkg.sv
// Package for the camera pose block: default widths, command and register codes,
// the CORDIC angle table and 32-bit saturation.
// Used by uvn_camera_pose_update; depends on nothing else.
package uvn_cam_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 20;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] RAD_TO_DEG_Q24  = 34'sd961263669;

  localparam logic [2:0] CMD_SLIDE   = 3'd0;
  localparam logic [2:0] CMD_ROLL    = 3'd1;
  localparam logic [2:0] CMD_PITCH   = 3'd2;
  localparam logic [2:0] CMD_YAW     = 3'd3;
  localparam logic [2:0] CMD_REBUILD = 3'd4;

  localparam logic [2:0] REG_INIT_EYE_X = 3'd0;
  localparam logic [2:0] REG_INIT_EYE_Y = 3'd1;
  localparam logic [2:0] REG_INIT_EYE_Z = 3'd2;
  localparam logic [2:0] REG_LOOK_X     = 3'd3;
  localparam logic [2:0] REG_LOOK_Y     = 3'd4;
  localparam logic [2:0] REG_LOOK_Z     = 3'd5;

  // step angle in degrees, 24 fraction bits
  function automatic logic signed [33:0] atan_step(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:    r = 34'sd754974720;
      5'd1:    r = 34'sd445687602;
      5'd2:    r = 34'sd235489088;
      5'd3:    r = 34'sd119537938;
      5'd4:    r = 34'sd60000934;
      5'd5:    r = 34'sd30029717;
      5'd6:    r = 34'sd15018523;
      5'd7:    r = 34'sd7509720;
      5'd8:    r = 34'sd3754917;
      5'd9:    r = 34'sd1877466;
      default: r = RAD_TO_DEG_Q24 >>> i;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: rtl/uvn_camera_pose_update.sv
// Camera pose block: eye and u/v/n axes, one view matrix result per command.
// Every product runs through one bit-serial multiplier (load, a shift-add step per
// bit of the 33-bit multiplier, accumulate). Slide takes 18 products; roll/pitch/yaw
// run a bit-serial mod-360 digit loop, CORDIC_STEPS CORDIC steps and 21 products;
// rebuild runs two normalizations with square root and serial divides, up to 21 products.
// One command at a time; the next one is taken the cycle after the result transfer.
// Synchronous active-high reset restores the pose.
module uvn_camera_pose_update #(
  parameter int FRAC_BITS    = uvn_cam_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = uvn_cam_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // delta_u, delta_v, delta_n, angle_deg
  input  logic [2:0]   s_tuser,   // command
  output logic         m_tvalid,
  input  logic         m_tready,
  // right_x/y/z, upvec_x/y/z, back_x/y/z, shift_u, shift_v, shift_n
  output logic [383:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int QW = 32 - FRAC_BITS;          // integer degree bits of the angle
  localparam int WRAP = (1 << QW) % 360;
  localparam int QB = FRAC_BITS + 1;           // quotient bits of a normalize divide
  localparam int NW = 31 + FRAC_BITS;          // dividend bits
  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [33:0] QUARTER = 34'sd90 <<< 24;
  localparam logic signed [33:0] HALFTURN = 34'sd180 <<< 24;
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MODR = 4'd1;
  localparam logic [3:0] ST_FOLD = 4'd2;
  localparam logic [3:0] ST_FOLD2 = 4'd3;
  localparam logic [3:0] ST_CORD = 4'd4;
  localparam logic [3:0] ST_CS = 4'd5;
  localparam logic [3:0] ST_LOAD = 4'd6;
  localparam logic [3:0] ST_MUL = 4'd7;
  localparam logic [3:0] ST_ACC = 4'd8;
  localparam logic [3:0] ST_NRM0 = 4'd9;
  localparam logic [3:0] ST_NSH = 4'd10;
  localparam logic [3:0] ST_SQRT = 4'd11;
  localparam logic [3:0] ST_DSET = 4'd12;
  localparam logic [3:0] ST_DIV = 4'd13;
  localparam logic [3:0] ST_DEND = 4'd14;
  localparam logic [3:0] ST_OUT = 4'd15;

  localparam logic [2:0] PH_SLIDE = 3'd0;
  localparam logic [2:0] PH_ROT = 3'd1;
  localparam logic [2:0] PH_SQ = 3'd2;
  localparam logic [2:0] PH_CROSS = 3'd3;
  localparam logic [2:0] PH_DOT = 3'd4;

  logic [3:0] state;
  logic [2:0] phase;
  logic [1:0] grp, kk;

  logic signed [31:0] init_eye [3];
  logic signed [31:0] look [3];
  logic signed [31:0] eye [3];
  logic signed [31:0] ax [3][3];   // rows u, v, n
  logic signed [31:0] shv [3];
  logic signed [31:0] dl [3];
  logic signed [31:0] ang;
  logic [1:0] ia, ib;
  logic signed [31:0] tmp;

  // angle reduction and CORDIC
  logic [QW-1:0] modsh;
  logic [9:0] mrem;
  logic [4:0] cnt;
  logic signed [33:0] zz, cx, cy;
  logic flip;
  logic signed [32:0] cc, ss;

  // serial multiplier and accumulation
  logic signed [32:0] op_a, op_b;
  logic op_neg, op_rnd;
  logic [32:0] mb;
  logic signed [65:0] sh, acc, sum;
  logic [5:0] mk;
  logic signed [65:0] val, sum_new;
  logic [1:0] klast, glast;

  // normalization
  logic signed [32:0] dv [3];
  logic [32:0] m [3];
  logic sg [3];
  logic [32:0] mx;
  logic pass;
  logic [63:0] sqx, res, bitr;
  logic [30:0] len;
  logic [1:0] di;
  logic [30:0] rem;
  logic [QB-1:0] nlow, quo;
  logic signed [31:0] nv [3];
  logic signed [31:0] uv [3];
  logic signed [31:0] vv [3];

  // combinational helpers
  logic [10:0] mr;
  logic signed [11:0] r1;
  logic signed [33:0] xs, ys, rx, ry, stp;
  logic [63:0] st;
  logic [31:0] r2;
  logic [NW-1:0] nn;
  logic [32:0] msel;
  logic signed [31:0] qs;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign cfg_ready = 1'b1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_tdata[32*i +: 32]      = ax[0][i];
      m_tdata[96 + 32*i +: 32] = ax[1][i];
      m_tdata[192 + 32*i +: 32] = ax[2][i];
      m_tdata[288 + 32*i +: 32] = shv[i];
    end
  end

  always_comb begin
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
  end

  // operand selection for the product sequence
  always_comb begin
    op_a = '0;
    op_b = '0;
    op_neg = 1'b0;
    op_rnd = 1'b1;
    klast = 2'd2;
    glast = 2'd2;
    case (phase)
      PH_SLIDE: begin
        op_a = 33'(dl[kk]);
        op_b = 33'(ax[kk][grp]);
      end
      PH_ROT: begin
        klast = 2'd3;
        case (kk)
          2'd0: begin op_a = cc; op_b = 33'(ax[ia][grp]); end
          2'd1: begin op_a = ss; op_b = 33'(ax[ib][grp]); op_neg = 1'b1; end
          2'd2: begin op_a = ss; op_b = 33'(ax[ia][grp]); end
          default: begin op_a = cc; op_b = 33'(ax[ib][grp]); end
        endcase
      end
      PH_SQ: begin
        op_a = $signed(m[kk]);
        op_b = $signed(m[kk]);
        op_rnd = 1'b0;
        glast = 2'd0;
      end
      PH_CROSS: begin
        klast = 2'd1;
        op_neg = kk[0];
        case ({grp, kk[0]})
          3'b000:  begin op_a = 33'(nv[1]); op_b = 33'(uv[2]); end
          3'b001:  begin op_a = 33'(nv[2]); op_b = 33'(uv[1]); end
          3'b010:  begin op_a = 33'(nv[2]); op_b = 33'(uv[0]); end
          3'b011:  begin op_a = 33'(nv[0]); op_b = 33'(uv[2]); end
          3'b100:  begin op_a = 33'(nv[0]); op_b = 33'(uv[1]); end
          default: begin op_a = 33'(nv[1]); op_b = 33'(uv[0]); end
        endcase
      end
      default: begin
        op_a = 33'sd0 - 33'(eye[kk]);
        op_b = 33'(ax[grp][kk]);
      end
    endcase
  end

  always_comb begin
    val = op_rnd ? ((acc + HALF) >>> FRAC_BITS) : acc;
    sum_new = op_neg ? (sum - val) : (sum + val);
    mr = {mrem, modsh[QW-1]};
    if (mr >= 11'd360) mr = mr - 11'd360;
    r1 = ang[31] ? ($signed({2'b00, mrem}) - 12'(WRAP)) : $signed({2'b00, mrem});
    if (r1 < 12'sd0) r1 = r1 + 12'sd360;
    if (r1 >= 12'sd180) r1 = r1 - 12'sd360;
    xs = cx >>> cnt;
    ys = cy >>> cnt;
    stp = uvn_cam_pkg::atan_step(cnt);
    rx = (cx + (34'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    ry = (cy + (34'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    st = res + bitr;
    r2 = {rem, nlow[QB-1]};
    msel = m[di];
    nn = NW'({msel[29:0], {FRAC_BITS{1'b0}}}) + NW'(len >> 1);
    qs = sg[di] ? (32'sd0 - $signed(32'(quo))) : $signed(32'(quo));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_DOT;
      for (int i = 0; i < 3; i++) begin
        init_eye[i] <= '0;
        look[i] <= '0;
        eye[i] <= '0;
        for (int j = 0; j < 3; j++) ax[i][j] <= (i == j) ? ONE_Q : 32'sd0;
      end
      init_eye[2] <= 32'sd5 <<< FRAC_BITS;
      eye[2] <= 32'sd5 <<< FRAC_BITS;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          uvn_cam_pkg::REG_INIT_EYE_X: init_eye[0] <= cfg_data;
          uvn_cam_pkg::REG_INIT_EYE_Y: init_eye[1] <= cfg_data;
          uvn_cam_pkg::REG_INIT_EYE_Z: init_eye[2] <= cfg_data;
          uvn_cam_pkg::REG_LOOK_X:     look[0] <= cfg_data;
          uvn_cam_pkg::REG_LOOK_Y:     look[1] <= cfg_data;
          uvn_cam_pkg::REG_LOOK_Z:     look[2] <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            dl[0] <= s_tdata[31:0];
            dl[1] <= s_tdata[63:32];
            dl[2] <= s_tdata[95:64];
            ang <= s_tdata[127:96];
            modsh <= s_tdata[127:128-QW];
            mrem <= '0;
            cnt <= '0;
            grp <= '0;
            kk <= '0;
            sum <= '0;
            pass <= 1'b0;
            unique case (s_tuser)
              uvn_cam_pkg::CMD_SLIDE: begin
                phase <= PH_SLIDE;
                sum <= 66'(eye[0]);
                state <= ST_LOAD;
              end
              uvn_cam_pkg::CMD_ROLL: begin
                ia <= 2'd0; ib <= 2'd1; state <= ST_MODR;
              end
              uvn_cam_pkg::CMD_PITCH: begin
                ia <= 2'd2; ib <= 2'd1; state <= ST_MODR;
              end
              uvn_cam_pkg::CMD_YAW: begin
                ia <= 2'd0; ib <= 2'd2; state <= ST_MODR;
              end
              uvn_cam_pkg::CMD_REBUILD: begin
                for (int i = 0; i < 3; i++) begin
                  eye[i] <= init_eye[i];
                  dv[i] <= 33'(init_eye[i]) - 33'(look[i]);
                end
                state <= ST_NRM0;
              end
              default: begin
                phase <= PH_DOT;
                state <= ST_LOAD;
              end
            endcase
          end
        end
        ST_MODR: begin
          // remainder of the integer degrees by 360, one bit per cycle
          mrem <= mr[9:0];
          modsh <= modsh << 1;
          cnt <= cnt + 5'd1;
          if (cnt == 5'(QW - 1)) state <= ST_FOLD;
        end
        ST_FOLD: begin
          zz <= (34'(r1) <<< 24) + (34'(ang[FRAC_BITS-1:0]) << (24 - FRAC_BITS));
          state <= ST_FOLD2;
        end
        ST_FOLD2: begin
          flip <= 1'b0;
          if (zz > QUARTER) begin
            zz <= zz - HALFTURN;
            flip <= 1'b1;
          end else if (zz < -QUARTER) begin
            zz <= zz + HALFTURN;
            flip <= 1'b1;
          end
          cx <= uvn_cam_pkg::CORDIC_GAIN_Q30;
          cy <= '0;
          cnt <= '0;
          state <= ST_CORD;
        end
        ST_CORD: begin
          if (zz >= 34'sd0) begin
            cx <= cx - ys; cy <= cy + xs; zz <= zz - stp;
          end else begin
            cx <= cx + ys; cy <= cy - xs; zz <= zz + stp;
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(CORDIC_STEPS - 1)) state <= ST_CS;
        end
        ST_CS: begin
          cc <= flip ? (33'sd0 - rx[32:0]) : rx[32:0];
          ss <= flip ? (33'sd0 - ry[32:0]) : ry[32:0];
          phase <= PH_ROT;
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          sh <= 66'(op_a);
          mb <= op_b;
          acc <= '0;
          mk <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          // shift-add, top multiplier bit carries negative weight
          if (mb[0]) acc <= (mk == 6'd32) ? (acc - sh) : (acc + sh);
          sh <= sh <<< 1;
          mb <= mb >> 1;
          mk <= mk + 6'd1;
          if (mk == 6'd32) state <= ST_ACC;
        end
        ST_ACC: begin
          state <= ST_LOAD;
          if (phase == PH_ROT && kk == 2'd1) begin
            tmp <= uvn_cam_pkg::sat32(sum_new);
            sum <= '0;
            kk <= 2'd2;
          end else if (kk != klast) begin
            kk <= kk + 2'd1;
            sum <= sum_new;
          end else begin
            kk <= '0;
            sum <= '0;
            case (phase)
              PH_SLIDE: eye[grp] <= uvn_cam_pkg::sat32(sum_new);
              PH_ROT: begin
                ax[ia][grp] <= tmp;
                ax[ib][grp] <= uvn_cam_pkg::sat32(sum_new);
              end
              PH_CROSS: vv[grp] <= uvn_cam_pkg::sat32(sum_new);
              PH_DOT: shv[grp] <= uvn_cam_pkg::sat32(sum_new);
              default: sqx <= sum_new[63:0];
            endcase
            if (grp != glast) begin
              grp <= grp + 2'd1;
              if (phase == PH_SLIDE) sum <= 66'(eye[grp + 2'd1]);
            end else begin
              grp <= '0;
              case (phase)
                PH_SQ: begin
                  res <= '0;
                  bitr <= 64'd1 << 62;
                  state <= ST_SQRT;
                end
                PH_CROSS: begin
                  for (int i = 0; i < 3; i++) begin
                    ax[0][i] <= uv[i];
                    ax[2][i] <= nv[i];
                  end
                  ax[1][0] <= vv[0];
                  ax[1][1] <= vv[1];
                  ax[1][2] <= uvn_cam_pkg::sat32(sum_new);
                  phase <= PH_DOT;
                end
                PH_DOT: state <= ST_OUT;
                default: phase <= PH_DOT;
              endcase
            end
          end
        end
        ST_NRM0: begin
          for (int i = 0; i < 3; i++) begin
            m[i] <= dv[i][32] ? 33'(-dv[i]) : 33'(dv[i]);
            sg[i] <= dv[i][32];
          end
          state <= ST_NSH;
        end
        ST_NSH: begin
          // bring the largest magnitude into [2^29, 2^30)
          if (mx == '0) begin
            phase <= PH_DOT;
            grp <= '0;
            kk <= '0;
            sum <= '0;
            state <= ST_LOAD;
          end else if (mx[32:30] != 3'd0) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else if (!mx[29]) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end else begin
            phase <= PH_SQ;
            grp <= '0;
            kk <= '0;
            sum <= '0;
            state <= ST_LOAD;
          end
        end
        ST_SQRT: begin
          if (sqx >= st) begin
            sqx <= sqx - st;
            res <= (res >> 1) + bitr;
          end else begin
            res <= res >> 1;
          end
          bitr <= bitr >> 2;
          if (bitr[0]) begin
            di <= '0;
            state <= ST_DSET;
          end
        end
        ST_DSET: begin
          if (bitr == '0 && di == 2'd0) len <= res[30:0];
          state <= ST_DIV;
          cnt <= '0;
          quo <= '0;
          if (bitr == '0 && di == 2'd0) begin
            // length just settled: take the dividend with it next cycle
            state <= ST_DSET;
            bitr <= 64'd1;
          end else begin
            rem <= 31'(nn[NW-1:QB]);
            nlow <= nn[QB-1:0];
          end
        end
        ST_DIV: begin
          if (r2 >= {1'b0, len}) begin
            rem <= 31'(r2 - {1'b0, len});
            quo <= {quo[QB-2:0], 1'b1};
          end else begin
            rem <= r2[30:0];
            quo <= {quo[QB-2:0], 1'b0};
          end
          nlow <= nlow << 1;
          cnt <= cnt + 5'd1;
          if (cnt == 5'(QB - 1)) state <= ST_DEND;
        end
        ST_DEND: begin
          if (!pass) nv[di] <= qs;
          else uv[di] <= qs;
          if (di != 2'd2) begin
            di <= di + 2'd1;
            state <= ST_DSET;
          end else if (!pass) begin
            dv[0] <= 33'(qs);
            dv[1] <= '0;
            dv[2] <= 33'sd0 - 33'(nv[0]);
            pass <= 1'b1;
            bitr <= '0;
            state <= ST_NRM0;
          end else begin
            phase <= PH_CROSS;
            grp <= '0;
            kk <= '0;
            sum <= '0;
            state <= ST_LOAD;
          end
        end
        ST_OUT: begin
          if (m_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
